// ===== design/lwbc_pkg.sv =====
`default_nettype none
package lwbc_pkg;

    localparam int ADDR_W      = 32;
    localparam int BLOCK_W     = 32;
    localparam int AGE_W       = 32;
    localparam int SHIFT_W     = 4;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;

    // result word: hit, writeback, victim block, zero pad to bytes
    localparam int M_TDATA_W   = 40;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [BLOCK_W-1:0] block;
        logic [AGE_W-1:0]   age;
    } line_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SUB,
        ST_RD,
        ST_CHK,
        ST_WRITE
    } state_t;

endpackage
`default_nettype wire

// ===== design/lwbc_ram.sv =====
`default_nettype none
module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/lru_writeback_cache_controller.sv =====
`default_nettype none
// Tag and state store of a set-associative, write-back, write-allocate cache
// with least-recently-used replacement. Each input word is one access: s_tuser
// is the write flag, s_tdata the byte address. The block number is the address
// shifted right by block_shift (set over the cfg port, reset value 5); the
// block number modulo NUM_SETS selects the set. A hit refreshes the way's age
// stamp (and sets dirty on a write); a miss fills the lowest invalid way, or
// else the way whose stamp is oldest relative to the wrapping 32-bit access
// counter, and reports a write-back with the victim's block number when that
// victim was dirty. One result word per access on m_tdata.
// After reset the block sweeps all NUM_SETS*WAYS lines of the line store, one
// per cycle, before s_tready rises. An access then goes through an accept step,
// then, when NUM_SETS is not a power of two, a multiply step and a subtract
// step for the set residue (multiply by a fixed reciprocal for the quotient,
// then subtract quotient times NUM_SETS), then per way examined a read of the
// line store and a pass through the shared compare unit (a hit stops the scan),
// then a write step. The result sits in an output register, so the next access
// is accepted while it waits for m_tready; that access then holds in its write
// step until the register drains.
module lru_writeback_cache_controller #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration: block_shift
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lwbc_pkg::SHIFT_W-1:0]     cfg_data,
    // access stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lwbc_pkg::ADDR_W-1:0]      s_tdata,   // [31:0] address
    input  wire logic                             s_tuser,   // [0] req_type
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lwbc_pkg::M_TDATA_W-1:0]        m_tdata    // [0] hit, [1] writeback,
                                                             // [33:2] victim_block, [39:34] 0
);

    localparam int NUM_LINES = NUM_SETS * WAYS;
    localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit SETS_POW2 = (NUM_SETS > 1) && ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam int WORD_W    = $bits(lwbc_pkg::line_word_t);
    localparam int BW        = lwbc_pkg::BLOCK_W;
    localparam int AGW       = lwbc_pkg::AGE_W;
    // reciprocal ceil(2^(BW+sh) / NUM_SETS) gives the exact quotient for any
    // BW-bit block number
    localparam int RECIP_SH  = $clog2(NUM_SETS);
    localparam longint unsigned RECIP_M =
        ((64'd1 << (BW + RECIP_SH)) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam logic [BW:0] RECIP_C = (BW + 1)'(RECIP_M);

    lwbc_pkg::state_t state_reg, state_next;

    logic [lwbc_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [AGW-1:0]                 count_reg, count_next;
    logic [LINE_W-1:0]              clr_reg, clr_next;
    logic                           m_valid_reg, m_valid_next;
    logic [lwbc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // per-access working registers
    logic                           wr_reg, wr_next;
    logic [BW-1:0]                  blk_reg, blk_next;
    logic [SET_W-1:0]               set_reg, set_next;
    logic [BW-1:0]                  quo_reg, quo_next;
    logic [WAY_W-1:0]               way_reg, way_next;
    logic                           hit_reg, hit_next;
    logic [WAY_W-1:0]               hit_way_reg, hit_way_next;
    logic                           hit_dirty_reg, hit_dirty_next;
    logic                           inv_reg, inv_next;
    logic [WAY_W-1:0]               inv_way_reg, inv_way_next;
    logic [WAY_W-1:0]               best_way_reg, best_way_next;
    logic [AGW-1:0]                 best_dist_reg, best_dist_next;
    logic                           best_dirty_reg, best_dirty_next;
    logic [BW-1:0]                  best_block_reg, best_block_next;

    // line store port
    logic                           ram_we;
    logic [LINE_W-1:0]              ram_waddr;
    lwbc_pkg::line_word_t           ram_wdata;
    logic [LINE_W-1:0]              ram_raddr;
    logic [WORD_W-1:0]              ram_rdata;
    lwbc_pkg::line_word_t           rd_word;

    // shared compare unit and helpers
    logic [AGW-1:0]                 age_gap;
    logic [2*BW:0]                  recip_prod;
    logic [WAY_W-1:0]               tgt_way;
    logic                           wb;
    logic                           out_free;
    logic [BW-1:0]                  s_blk;

    lwbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_LINES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word   = lwbc_pkg::line_word_t'(ram_rdata);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == lwbc_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign s_blk      = s_tdata >> shift_reg;
    assign age_gap    = count_reg - rd_word.age;
    assign recip_prod = (2*BW + 1)'(blk_reg) * (2*BW + 1)'(RECIP_C);
    assign out_free   = !m_valid_reg || m_tready;
    assign ram_raddr  = LINE_W'(32'(set_reg) * 32'(WAYS) + 32'(way_reg));

    // fill target: hit way, else first empty way, else oldest way
    assign tgt_way = hit_reg ? hit_way_reg : (inv_reg ? inv_way_reg : best_way_reg);
    assign wb      = !hit_reg && !inv_reg && best_dirty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lwbc_pkg::ST_CLEAR;
            shift_reg   <= lwbc_pkg::SHIFT_RESET;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        wr_reg         <= wr_next;
        blk_reg        <= blk_next;
        set_reg        <= set_next;
        quo_reg        <= quo_next;
        way_reg        <= way_next;
        hit_reg        <= hit_next;
        hit_way_reg    <= hit_way_next;
        hit_dirty_reg  <= hit_dirty_next;
        inv_reg        <= inv_next;
        inv_way_reg    <= inv_way_next;
        best_way_reg   <= best_way_next;
        best_dist_reg  <= best_dist_next;
        best_dirty_reg <= best_dirty_next;
        best_block_reg <= best_block_next;
    end

    always_comb begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        wr_next         = wr_reg;
        blk_next        = blk_reg;
        set_next        = set_reg;
        quo_next        = quo_reg;
        way_next        = way_reg;
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        hit_dirty_next  = hit_dirty_reg;
        inv_next        = inv_reg;
        inv_way_next    = inv_way_reg;
        best_way_next   = best_way_reg;
        best_dist_next  = best_dist_reg;
        best_dirty_next = best_dirty_reg;
        best_block_next = best_block_reg;
        ram_we          = 1'b0;
        ram_waddr       = LINE_W'(32'(set_reg) * 32'(WAYS) + 32'(tgt_way));
        ram_wdata       = '0;

        // drop the result word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            shift_next = cfg_data;
        end

        case (state_reg)
            lwbc_pkg::ST_CLEAR: begin
                // invalidate every line, one per cycle
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LINE_W'(NUM_LINES - 1)) begin
                    state_next = lwbc_pkg::ST_IDLE;
                end
            end
            lwbc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    wr_next   = s_tuser;
                    blk_next  = s_blk;
                    way_next  = '0;
                    hit_next  = 1'b0;
                    inv_next  = 1'b0;
                    if (SETS_POW2) begin
                        set_next   = s_blk[SET_W-1:0];
                        state_next = lwbc_pkg::ST_RD;
                    end else begin
                        state_next = lwbc_pkg::ST_MOD;
                    end
                end
            end
            lwbc_pkg::ST_MOD: begin
                // quotient from the reciprocal product
                quo_next   = BW'(recip_prod >> (BW + RECIP_SH));
                state_next = lwbc_pkg::ST_SUB;
            end
            lwbc_pkg::ST_SUB: begin
                // residue: block minus quotient times NUM_SETS
                set_next   = SET_W'(blk_reg - quo_reg * BW'(NUM_SETS));
                state_next = lwbc_pkg::ST_RD;
            end
            lwbc_pkg::ST_RD: begin
                // read address is issued from set_reg/way_reg
                state_next = lwbc_pkg::ST_CHK;
            end
            lwbc_pkg::ST_CHK: begin
                if (rd_word.valid && (rd_word.block == blk_reg)) begin
                    hit_next       = 1'b1;
                    hit_way_next   = way_reg;
                    hit_dirty_next = rd_word.dirty;
                    state_next     = lwbc_pkg::ST_WRITE;
                end else begin
                    if (!rd_word.valid && !inv_reg) begin
                        inv_next     = 1'b1;
                        inv_way_next = way_reg;
                    end
                    // oldest way wins, ties keep the lower way
                    if ((way_reg == '0) || (age_gap > best_dist_reg)) begin
                        best_way_next   = way_reg;
                        best_dist_next  = age_gap;
                        best_dirty_next = rd_word.dirty;
                        best_block_next = rd_word.block;
                    end
                    if (way_reg == WAY_W'(WAYS - 1)) begin
                        state_next = lwbc_pkg::ST_WRITE;
                    end else begin
                        way_next   = way_reg + 1'b1;
                        state_next = lwbc_pkg::ST_RD;
                    end
                end
            end
            lwbc_pkg::ST_WRITE: begin
                // hold until the output register is free
                if (out_free) begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.dirty = hit_reg ? (hit_dirty_reg | wr_reg) : wr_reg;
                    ram_wdata.block = blk_reg;
                    ram_wdata.age   = count_reg;
                    count_next      = count_reg + 1'b1;
                    m_valid_next    = 1'b1;
                    m_data_next     = {6'd0, (wb ? best_block_reg : {BW{1'b0}}), wb, hit_reg};
                    state_next      = lwbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lwbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
